// ----- design/svnb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// svnb_pkg
// Shared constants, codes and types of the smooth vertex normal builder.
// ----------------------------------------------------------------------------
package svnb_pkg;

    localparam int VERTEX_MAX_DEF = 4096;
    localparam int COORD_BITS_DEF = 16;

    localparam int IDX_IN_W    = 32;
    localparam int FIELD_W     = 16;
    localparam int ACC_W       = 48;
    localparam int CFG_W       = 13;
    localparam int APB_DW      = 32;
    localparam int APB_AW      = 3;
    localparam int REQ_W       = 2;
    localparam int S_DATA_W    = 3 * IDX_IN_W + 3 * FIELD_W;
    localparam int M_DATA_W    = 3 * FIELD_W;
    localparam int QUEUE_DEPTH = 2;

    // normaliser widths: magnitudes scaled below 2^30, length below 2^31
    localparam int MAG_W  = 30;
    localparam int LEN_W  = 31;
    localparam int SQ_W   = 64;
    localparam int FRAC_W = 15;
    localparam int NUM_W  = MAG_W + FIELD_W;

    localparam logic [FIELD_W-1:0] Q_MAX = 16'h7FFF;
    localparam logic signed [ACC_W-1:0] ACC_HI = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_LO = {1'b1, {(ACC_W-1){1'b0}}};

    // register index taken from paddr[2]
    localparam logic REG_VERTEX_COUNT = 1'b0;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD = 2'd0,
        REQ_TRI  = 2'd1,
        REQ_READ = 2'd2
    } req_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_POS_RD,
        B_EDGE,
        B_MUL,
        B_ACC_RD,
        B_ACC_WR,
        B_RD_ACC,
        B_RD_WAIT,
        B_NORM
    } back_state_t;

    typedef enum logic [2:0] {
        N_IDLE,
        N_SHIFT,
        N_SQ,
        N_SQRT,
        N_DIV_SET,
        N_DIV,
        N_DONE
    } norm_state_t;

    typedef struct packed {
        logic [FIELD_W-1:0] nz;
        logic [FIELD_W-1:0] ny;
        logic [FIELD_W-1:0] nx;
        logic               degen;
    } norm_res_t;

endpackage
`default_nettype wire

// ----- design/svnb_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// svnb_front
// Input classifier: range checks each word and packs kept ones as commands.
// ----------------------------------------------------------------------------
module svnb_front
    import svnb_pkg::*;
#(
    parameter int VERTEX_MAX = VERTEX_MAX_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [S_DATA_W-1:0]     s_tdata,
    input  wire logic [REQ_W-1:0]        s_tuser,
    input  wire logic [CFG_W-1:0]        vertex_count,
    input  wire logic                    q_full,
    output logic                         push,
    output logic [REQ_W+3*((VERTEX_MAX > 1) ? $clog2(VERTEX_MAX) : 1)
                  +3*COORD_BITS-1:0]     cmd
);

    localparam int IDX_W = (VERTEX_MAX > 1) ? $clog2(VERTEX_MAX) : 1;
    localparam int EXT_W = (COORD_BITS > FIELD_W) ? COORD_BITS : FIELD_W;

    logic [IDX_IN_W-1:0] va, vb, vc, lim;
    logic [EXT_W-1:0]    ex, ey, ez;
    logic                a_ok, b_ok, c_ok, keep;

    always_comb
    begin
        va = s_tdata[IDX_IN_W-1:0];
        vb = s_tdata[2*IDX_IN_W-1:IDX_IN_W];
        vc = s_tdata[3*IDX_IN_W-1:2*IDX_IN_W];
        ex = EXT_W'(s_tdata[3*IDX_IN_W +: FIELD_W]);
        ey = EXT_W'(s_tdata[3*IDX_IN_W+FIELD_W +: FIELD_W]);
        ez = EXT_W'(s_tdata[3*IDX_IN_W+2*FIELD_W +: FIELD_W]);

        lim = (IDX_IN_W'(vertex_count) < IDX_IN_W'(VERTEX_MAX)) ?
              IDX_IN_W'(vertex_count) : IDX_IN_W'(VERTEX_MAX);
        a_ok = va < lim;
        b_ok = vb < lim;
        c_ok = vc < lim;

        unique case (req_t'(s_tuser))
            REQ_LOAD, REQ_READ: keep = a_ok;
            REQ_TRI:            keep = a_ok && b_ok && c_ok;
            default:            keep = 1'b0;
        endcase

        s_tready = !q_full;
        push     = s_tvalid && !q_full && keep;
        cmd      = {ez[COORD_BITS-1:0], ey[COORD_BITS-1:0], ex[COORD_BITS-1:0],
                    vc[IDX_W-1:0], vb[IDX_W-1:0], va[IDX_W-1:0], s_tuser};
    end

endmodule
`default_nettype wire

// ----- design/svnb_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// svnb_queue
// Short command queue between the classifier and the sequencer.
// ----------------------------------------------------------------------------
module svnb_queue
    import svnb_pkg::*;
#(
    parameter int W = 8
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire logic [W-1:0] din,
    output logic              full,
    input  wire logic         pop,
    output logic              valid,
    output logic [W-1:0]      dout
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [W-1:0]     slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_reg, rd_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign full  = cnt_reg == CNT_W'(QUEUE_DEPTH);
    assign valid = cnt_reg != '0;
    assign dout  = slot_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= (wr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            if (pop)
                rd_reg <= (rd_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= din;
    end

endmodule
`default_nettype wire

// ----- design/svnb_norm.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// svnb_norm
// Iterative normaliser: scale, sum of squares, bitwise root, restoring divide.
// ----------------------------------------------------------------------------
module svnb_norm
    import svnb_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic signed [ACC_W-1:0] acc_x,
    input  wire logic signed [ACC_W-1:0] acc_y,
    input  wire logic signed [ACC_W-1:0] acc_z,
    output logic                         done,
    output norm_res_t                    res
);

    norm_state_t state_reg, state_next;

    logic [ACC_W-1:0]     m_reg [3];
    logic [2:0]           neg_reg;
    logic [ACC_W-1:0]     mx_reg;
    logic [1:0]           k_reg;
    logic [3:0]           it_reg;
    logic [2*MAG_W-1:0]   prod_reg;
    logic [SQ_W-1:0]      v_reg, r_reg, bit_reg;
    logic [LEN_W-1:0]     len_reg;
    logic [NUM_W-1:0]     num_reg;
    logic [LEN_W:0]       rem_reg;
    logic [FIELD_W-1:0]   q_reg;
    norm_res_t            res_reg;

    logic [ACC_W-1:0]     mag_x, mag_y, mag_z, mag_max;
    logic [SQ_W-1:0]      trial;
    logic                 take;
    logic [SQ_W-1:0]      r_nx;
    logic [NUM_W-1:0]     num_c;
    logic [LEN_W:0]       sh;
    logic                 ge;
    logic [FIELD_W-1:0]   q_nx, q_cap, q_sgn;

    always_comb
    begin
        mag_x   = acc_x[ACC_W-1] ? ACC_W'(-acc_x) : ACC_W'(acc_x);
        mag_y   = acc_y[ACC_W-1] ? ACC_W'(-acc_y) : ACC_W'(acc_y);
        mag_z   = acc_z[ACC_W-1] ? ACC_W'(-acc_z) : ACC_W'(acc_z);
        mag_max = (mag_x > mag_y) ? mag_x : mag_y;
        if (mag_z > mag_max)
            mag_max = mag_z;

        trial = r_reg + bit_reg;
        take  = v_reg >= trial;
        r_nx  = take ? ((r_reg >> 1) + bit_reg) : (r_reg >> 1);

        num_c = NUM_W'({m_reg[k_reg][MAG_W-1:0], {FRAC_W{1'b0}}})
              + NUM_W'(len_reg >> 1);

        sh    = {rem_reg[LEN_W-1:0], num_reg[FIELD_W-1]};
        ge    = sh >= {1'b0, len_reg};
        q_nx  = {q_reg[FIELD_W-2:0], ge};
        q_cap = q_nx[FIELD_W-1] ? Q_MAX : q_nx;
        q_sgn = neg_reg[k_reg] ? FIELD_W'(-q_cap) : q_cap;
    end

    always_comb
    begin
        state_next = state_reg;
        done       = 1'b0;
        unique case (state_reg)
            N_IDLE:
                if (start)
                    state_next = (mag_max == '0) ? N_DONE : N_SHIFT;
            N_SHIFT:
                if (mx_reg[ACC_W-1:MAG_W] == '0)
                    state_next = N_SQ;
            N_SQ:
                if (k_reg == 2'd3)
                    state_next = N_SQRT;
            N_SQRT:
                if (bit_reg[0])
                    state_next = N_DIV_SET;
            N_DIV_SET:
                state_next = N_DIV;
            N_DIV:
                if (it_reg == 4'd15)
                    state_next = (k_reg == 2'd2) ? N_DONE : N_DIV_SET;
            N_DONE:
            begin
                done       = 1'b1;
                state_next = N_IDLE;
            end
            default:
                state_next = N_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= N_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            N_IDLE:
                if (start)
                begin
                    m_reg[0] <= mag_x;
                    m_reg[1] <= mag_y;
                    m_reg[2] <= mag_z;
                    mx_reg   <= mag_max;
                    neg_reg  <= {acc_z[ACC_W-1], acc_y[ACC_W-1], acc_x[ACC_W-1]};
                    k_reg    <= '0;
                    v_reg    <= '0;
                    res_reg  <= '{nz: '0, ny: Q_MAX, nx: '0, degen: 1'b1};
                end
            N_SHIFT:
                if (mx_reg[ACC_W-1:MAG_W] != '0)
                begin
                    m_reg[0] <= m_reg[0] >> 1;
                    m_reg[1] <= m_reg[1] >> 1;
                    m_reg[2] <= m_reg[2] >> 1;
                    mx_reg   <= mx_reg >> 1;
                end
            N_SQ:
            begin
                if (k_reg != 2'd3)
                    prod_reg <= m_reg[k_reg][MAG_W-1:0] * m_reg[k_reg][MAG_W-1:0];
                if (k_reg != 2'd0)
                    v_reg <= v_reg + SQ_W'(prod_reg);
                k_reg   <= k_reg + 1'b1;
                r_reg   <= '0;
                bit_reg <= SQ_W'(1) << (SQ_W - 2);
                res_reg.degen <= 1'b0;
            end
            N_SQRT:
            begin
                if (take)
                    v_reg <= v_reg - trial;
                r_reg   <= r_nx;
                bit_reg <= bit_reg >> 2;
                len_reg <= r_nx[LEN_W-1:0];
                k_reg   <= '0;
            end
            N_DIV_SET:
            begin
                num_reg <= num_c;
                rem_reg <= (LEN_W+1)'(num_c >> FIELD_W);
                it_reg  <= '0;
            end
            N_DIV:
            begin
                rem_reg <= ge ? (sh - {1'b0, len_reg}) : sh;
                num_reg <= num_reg << 1;
                q_reg   <= q_nx;
                it_reg  <= it_reg + 1'b1;
                if (it_reg == 4'd15)
                begin
                    k_reg <= k_reg + 1'b1;
                    unique case (k_reg)
                        2'd0:    res_reg.nx <= q_sgn;
                        2'd1:    res_reg.ny <= q_sgn;
                        default: res_reg.nz <= q_sgn;
                    endcase
                end
            end
            default:
            begin
            end
        endcase
    end

    assign res = res_reg;

endmodule
`default_nettype wire

// ----- design/svnb_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// svnb_back
// Command sequencer: position and accumulator memories, cross product,
// saturating accumulate, normalise and output register.
// ----------------------------------------------------------------------------
module svnb_back
    import svnb_pkg::*;
#(
    parameter int VERTEX_MAX = VERTEX_MAX_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    q_valid,
    input  wire logic [REQ_W+3*((VERTEX_MAX > 1) ? $clog2(VERTEX_MAX) : 1)
                       +3*COORD_BITS-1:0] cmd,
    output logic                         pop,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [M_DATA_W-1:0]          m_tdata,
    output logic                         m_tuser
);

    localparam int IDX_W  = (VERTEX_MAX > 1) ? $clog2(VERTEX_MAX) : 1;
    localparam int EDGE_W = COORD_BITS + 1;
    localparam int PROD_W = 2 * EDGE_W;
    localparam int CR_W   = PROD_W + 1;
    localparam int SUM_W  = ((CR_W > ACC_W) ? CR_W : ACC_W) + 1;
    localparam int POS_W  = 3 * COORD_BITS;
    localparam int ACCM_W = 3 * ACC_W;
    localparam int P_OFS  = REQ_W + 3 * IDX_W;
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(ACC_HI);
    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(ACC_LO);

    back_state_t state_reg, state_next;

    logic [POS_W-1:0]  pos_mem [VERTEX_MAX];
    logic [ACCM_W-1:0] acc_mem [VERTEX_MAX];
    logic [POS_W-1:0]  pos_q_reg;
    logic [ACCM_W-1:0] acc_q_reg;

    logic [IDX_W-1:0]         corner_reg [3];
    logic [1:0]               j_reg;
    logic [2:0]               s_reg;
    logic [POS_W-1:0]         pt_reg [3];
    logic signed [EDGE_W-1:0] e1_reg [3];
    logic signed [EDGE_W-1:0] e2_reg [3];
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [CR_W-1:0]   cr_reg [3];
    logic                     out_valid_reg;
    norm_res_t                out_reg;

    logic              pos_we, pos_re, acc_we, acc_re;
    logic [IDX_W-1:0]  pos_addr, acc_addr;
    logic [POS_W-1:0]  pos_wdata;
    logic [ACCM_W-1:0] acc_wdata;
    logic              norm_start, norm_done;
    norm_res_t         norm_res;

    logic [IDX_W-1:0]         ca, cb, cc;
    logic signed [EDGE_W-1:0] op_a, op_b;
    logic [ACCM_W-1:0]        acc_sum;
    logic signed [ACC_W-1:0]  acc_k;
    logic signed [SUM_W-1:0]  sum_k;
    logic [2:0]               s_prev;

    assign ca = cmd[REQ_W +: IDX_W];
    assign cb = cmd[REQ_W+IDX_W +: IDX_W];
    assign cc = cmd[REQ_W+2*IDX_W +: IDX_W];

    // saturating accumulate of the three components
    always_comb
    begin
        acc_sum = '0;
        acc_k   = '0;
        sum_k   = '0;
        for (int k = 0; k < 3; k++)
        begin
            acc_k = acc_q_reg[k*ACC_W +: ACC_W];
            sum_k = SUM_W'(acc_k) + SUM_W'(cr_reg[k]);
            if (sum_k > SAT_HI)
                acc_sum[k*ACC_W +: ACC_W] = ACC_HI;
            else if (sum_k < SAT_LO)
                acc_sum[k*ACC_W +: ACC_W] = ACC_LO;
            else
                acc_sum[k*ACC_W +: ACC_W] = sum_k[ACC_W-1:0];
        end
    end

    // operand pairs of the cross product, one product a cycle
    always_comb
    begin
        s_prev = s_reg - 3'd1;
        unique case (s_reg)
            3'd0:    begin op_a = e1_reg[1]; op_b = e2_reg[2]; end
            3'd1:    begin op_a = e1_reg[2]; op_b = e2_reg[1]; end
            3'd2:    begin op_a = e1_reg[2]; op_b = e2_reg[0]; end
            3'd3:    begin op_a = e1_reg[0]; op_b = e2_reg[2]; end
            3'd4:    begin op_a = e1_reg[0]; op_b = e2_reg[1]; end
            default: begin op_a = e1_reg[1]; op_b = e2_reg[0]; end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        pos_we     = 1'b0;
        pos_re     = 1'b0;
        acc_we     = 1'b0;
        acc_re     = 1'b0;
        pos_addr   = ca;
        acc_addr   = ca;
        pos_wdata  = cmd[P_OFS +: POS_W];
        acc_wdata  = '0;
        norm_start = 1'b0;
        unique case (state_reg)
            B_IDLE:
                if (q_valid)
                begin
                    pop = 1'b1;
                    unique case (req_t'(cmd[REQ_W-1:0]))
                        REQ_LOAD:
                        begin
                            pos_we = 1'b1;
                            acc_we = 1'b1;
                        end
                        REQ_TRI:  state_next = B_POS_RD;
                        REQ_READ: state_next = B_RD_ACC;
                        default:  state_next = B_IDLE;
                    endcase
                end
            B_POS_RD:
            begin
                if (j_reg != 2'd3)
                begin
                    pos_re   = 1'b1;
                    pos_addr = corner_reg[j_reg];
                end
                else
                    state_next = B_EDGE;
            end
            B_EDGE:
                state_next = B_MUL;
            B_MUL:
                if (s_reg == 3'd6)
                    state_next = B_ACC_RD;
            B_ACC_RD:
            begin
                acc_re     = 1'b1;
                acc_addr   = corner_reg[j_reg];
                state_next = B_ACC_WR;
            end
            B_ACC_WR:
            begin
                acc_we     = 1'b1;
                acc_addr   = corner_reg[j_reg];
                acc_wdata  = acc_sum;
                state_next = (j_reg == 2'd2) ? B_IDLE : B_ACC_RD;
            end
            B_RD_ACC:
            begin
                acc_re     = 1'b1;
                acc_addr   = corner_reg[0];
                state_next = B_RD_WAIT;
            end
            B_RD_WAIT:
                if (!out_valid_reg)
                begin
                    norm_start = 1'b1;
                    state_next = B_NORM;
                end
            B_NORM:
                if (norm_done)
                    state_next = B_IDLE;
            default:
                state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (norm_done)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (norm_done)
            out_reg <= norm_res;
        unique case (state_reg)
            B_IDLE:
            begin
                corner_reg[0] <= ca;
                corner_reg[1] <= cb;
                corner_reg[2] <= cc;
                j_reg         <= '0;
            end
            B_POS_RD:
            begin
                if (j_reg != 2'd0)
                    pt_reg[j_reg - 2'd1] <= pos_q_reg;
                j_reg <= j_reg + 1'b1;
            end
            B_EDGE:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    e1_reg[k] <= EDGE_W'($signed(pt_reg[1][k*COORD_BITS +: COORD_BITS]))
                               - EDGE_W'($signed(pt_reg[0][k*COORD_BITS +: COORD_BITS]));
                    e2_reg[k] <= EDGE_W'($signed(pt_reg[2][k*COORD_BITS +: COORD_BITS]))
                               - EDGE_W'($signed(pt_reg[0][k*COORD_BITS +: COORD_BITS]));
                end
                s_reg <= '0;
                j_reg <= '0;
            end
            B_MUL:
            begin
                prod_reg <= op_a * op_b;
                if (s_reg != 3'd0)
                begin
                    if (s_prev[0])
                        cr_reg[s_prev[2:1]] <= cr_reg[s_prev[2:1]] - CR_W'(prod_reg);
                    else
                        cr_reg[s_prev[2:1]] <= CR_W'(prod_reg);
                end
                s_reg <= s_reg + 1'b1;
            end
            B_ACC_WR:
                j_reg <= j_reg + 1'b1;
            default:
            begin
            end
        endcase
    end

    // single port memories, registered read
    always_ff @(posedge clk)
    begin
        if (pos_we)
            pos_mem[pos_addr] <= pos_wdata;
        if (pos_re)
            pos_q_reg <= pos_mem[pos_addr];
    end

    always_ff @(posedge clk)
    begin
        if (acc_we)
            acc_mem[acc_addr] <= acc_wdata;
        if (acc_re)
            acc_q_reg <= acc_mem[acc_addr];
    end

    svnb_norm u_norm
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (norm_start),
        .acc_x (acc_q_reg[0 +: ACC_W]),
        .acc_y (acc_q_reg[ACC_W +: ACC_W]),
        .acc_z (acc_q_reg[2*ACC_W +: ACC_W]),
        .done  (norm_done),
        .res   (norm_res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.nz, out_reg.ny, out_reg.nx};
    assign m_tuser  = out_reg.degen;

endmodule
`default_nettype wire

// ----- design/smooth_vertex_normal_builder.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// smooth_vertex_normal_builder
// Area-weighted smooth vertex normals in fixed point.
// ----------------------------------------------------------------------------
// Input stream s_*: one word per request (load position, add triangle, read
// normal); tuser holds the request kind. Out-of-range or unused requests are
// dropped by the classifier and give no result. Output stream m_*: one word
// per read, Q1.15 normal, tuser set when the accumulated vector was zero.
// The user writes vertex_count over APB at address 0 only while the block is
// idle; the block does not enforce it. A two-word queue between classifier and
// sequencer lets input words in while a result waits in the output register.
// Work per request in the sequencer (single-port memories, one multiplier for
//   the cross product): load writes both memories; triangle does three position
//   reads, six products and three accumulator read-modify-writes; a read of a
//   zero vector skips the normaliser steps, else it runs the shift search, the
//   32-step square root and a 16-step divide per component.
// Reset clears control state and vertex_count; the memories are not cleared,
// a load initialises an entry. A stalled output holds its word and the next
// read waits before normalising; the input backs up once the queue fills.
// ----------------------------------------------------------------------------
module smooth_vertex_normal_builder
    import svnb_pkg::*;
#(
    parameter int VERTEX_MAX = VERTEX_MAX_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [APB_AW-1:0]   paddr,
    input  wire logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]        prdata,
    output logic                     pready,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // vertex_a, vertex_b, vertex_c, pos_x, pos_y, pos_z
    input  wire logic [S_DATA_W-1:0] s_tdata,
    // req_type
    input  wire logic [REQ_W-1:0]    s_tuser,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // normal_x, normal_y, normal_z
    output logic [M_DATA_W-1:0]      m_tdata,
    // degenerate
    output logic                     m_tuser
);

    localparam int IDX_W = (VERTEX_MAX > 1) ? $clog2(VERTEX_MAX) : 1;
    localparam int CMD_W = REQ_W + 3 * IDX_W + 3 * COORD_BITS;

    logic [CFG_W-1:0] vc_reg;
    logic             push, q_full, q_valid, pop;
    logic [CMD_W-1:0] cmd_in, cmd_out;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_VERTEX_COUNT) ? APB_DW'(vc_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vc_reg <= '0;
        else if (psel && penable && pwrite && paddr[2] == REG_VERTEX_COUNT)
            vc_reg <= pwdata[CFG_W-1:0];
    end

    svnb_front #(.VERTEX_MAX(VERTEX_MAX), .COORD_BITS(COORD_BITS)) u_front
    (
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .vertex_count (vc_reg),
        .q_full       (q_full),
        .push         (push),
        .cmd          (cmd_in)
    );

    svnb_queue #(.W(CMD_W)) u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (cmd_in),
        .full  (q_full),
        .pop   (pop),
        .valid (q_valid),
        .dout  (cmd_out)
    );

    svnb_back #(.VERTEX_MAX(VERTEX_MAX), .COORD_BITS(COORD_BITS)) u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .cmd      (cmd_out),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    a_degen_up: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == {16'd0, Q_MAX, 16'd0})
        else $error("degenerate word is not the up normal");

    a_no_min: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[15:0] != 16'h8000
            && m_tdata[31:16] != 16'h8000 && m_tdata[47:32] != 16'h8000)
        else $error("normal component out of Q1.15 range");

    a_full_after_push: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_tready) |-> $past(push))
        else $error("queue filled without a push");

    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("pop from empty queue");

endmodule
`default_nettype wire
